>>> hdl/pjs_pkg.sv
// Shared types and constants for the priority job scheduler.
// No dependencies.
package pjs_pkg;

    typedef enum logic [2:0] {
        OP_SUBMIT     = 3'd0,
        OP_SUBMIT_REC = 3'd1,
        OP_DISPATCH   = 3'd2,
        OP_ACK        = 3'd3,
        OP_CANCEL     = 3'd4,
        OP_RESCHED    = 3'd5
    } op_t;

    localparam logic [15:0] TIMEOUT_RESET = 16'd30;
    localparam int          OP_W          = 3;
    localparam int          SLOT_W        = 4;
    localparam int          PRIO_W        = 16;
    localparam int          TIME_W        = 32;

    // One queued command, passed from the front end to the execution unit.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] tval;
        logic [TIME_W-1:0] period;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0] picked_slot;
        logic              picked_valid;
        logic              op_ok;
    } res_t;

endpackage

>>> hdl/pjs_cmd_fifo.sv
// Two-entry command queue between the front end and the execution unit.
// Depends on pjs_pkg.
module pjs_cmd_fifo
    import pjs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);
    cmd_t       mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

>>> hdl/pjs_exec.sv
// Execution unit: slot table, sequential dispatch scan and result register.
// Depends on pjs_pkg.
module pjs_exec
    import pjs_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    input  logic [15:0] stuck_timeout,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK
    } state_t;

    state_t                   state_reg;
    logic [SLOTS-1:0]         present_reg;
    logic [SLOTS-1:0]         running_reg;
    logic [SLOTS-1:0]         recurring_reg;
    logic signed [PRIO_W-1:0] prio_reg   [SLOTS];
    logic [TIME_W-1:0]        due_reg    [SLOTS];
    logic [TIME_W-1:0]        period_reg [SLOTS];

    logic [CNT_W-1:0]         idx_reg;
    logic [TIME_W-1:0]        now_reg;
    logic                     best_valid_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic signed [PRIO_W-1:0] best_prio_reg;
    logic [TIME_W-1:0]        best_due_reg;
    logic                     res_valid_reg;
    res_t                     res_reg;

    logic [IDX_W-1:0]         cur;
    logic                     stuck;
    logic                     idle_now;
    logic                     better;
    logic                     slot_in_range;
    logic [IDX_W-1:0]         cmd_idx;
    logic                     cmd_ok;
    logic                     accept;

    assign cur       = idx_reg[IDX_W-1:0];
    assign cmd_ready = (state_reg == ST_IDLE) && !res_valid_reg;
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Slot ids outside the table are ignored; the field may be wider or narrower.
    always_comb
    begin
        slot_in_range = ({28'd0, cmd.slot} < 32'(SLOTS));
        cmd_idx       = IDX_W'(cmd.slot);
        cmd_ok        = slot_in_range && (cmd.op == OP_CANCEL || cmd.op == OP_RESCHED) &&
                        present_reg[cmd_idx];
    end

    // Per-slot step of the scan: release a stuck job, then compare as a candidate.
    always_comb
    begin
        stuck = present_reg[cur] && running_reg[cur] &&
                (({1'b0, due_reg[cur]} + {17'd0, stuck_timeout}) < {1'b0, now_reg});
        idle_now = present_reg[cur] && (!running_reg[cur] || stuck) &&
                   (due_reg[cur] <= now_reg);
        better = !best_valid_reg || (prio_reg[cur] > best_prio_reg) ||
                 ((prio_reg[cur] == best_prio_reg) && (due_reg[cur] < best_due_reg));
    end

    always_ff @(posedge clk)
    begin
        if (accept && slot_in_range &&
            (cmd.op == OP_SUBMIT || cmd.op == OP_SUBMIT_REC))
        begin
            prio_reg[cmd_idx]   <= cmd.prio;
            due_reg[cmd_idx]    <= cmd.tval;
            period_reg[cmd_idx] <= (cmd.op == OP_SUBMIT_REC) ? cmd.period : '0;
        end
        else if (accept && slot_in_range && cmd.op == OP_RESCHED && present_reg[cmd_idx])
        begin
            due_reg[cmd_idx] <= cmd.tval;
        end
        else if (accept && slot_in_range && cmd.op == OP_ACK &&
                 present_reg[cmd_idx] && running_reg[cmd_idx] && recurring_reg[cmd_idx])
        begin
            due_reg[cmd_idx] <= due_reg[cmd_idx] + period_reg[cmd_idx];
        end
        else if (state_reg == ST_PICK && best_valid_reg)
        begin
            due_reg[best_idx_reg] <= now_reg;
        end
        if (state_reg == ST_SCAN && idle_now && better)
        begin
            best_idx_reg  <= cur;
            best_prio_reg <= prio_reg[cur];
            best_due_reg  <= due_reg[cur];
        end
        if (accept)
        begin
            now_reg <= cmd.tval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            present_reg    <= '0;
            running_reg    <= '0;
            recurring_reg  <= '0;
            idx_reg        <= '0;
            best_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd.op == OP_DISPATCH)
                        begin
                            idx_reg        <= '0;
                            best_valid_reg <= 1'b0;
                            state_reg      <= ST_SCAN;
                        end
                        else
                        begin
                            res_valid_reg <= 1'b1;
                            res_reg       <= {SLOT_W'(0), 1'b0, cmd_ok};
                            if (slot_in_range)
                            begin
                                case (cmd.op)
                                    OP_SUBMIT, OP_SUBMIT_REC:
                                    begin
                                        present_reg[cmd_idx]   <= 1'b1;
                                        running_reg[cmd_idx]   <= 1'b0;
                                        recurring_reg[cmd_idx] <= (cmd.op == OP_SUBMIT_REC);
                                    end
                                    OP_ACK:
                                    begin
                                        if (present_reg[cmd_idx] && running_reg[cmd_idx])
                                        begin
                                            running_reg[cmd_idx] <= 1'b0;
                                            if (!recurring_reg[cmd_idx])
                                            begin
                                                present_reg[cmd_idx] <= 1'b0;
                                            end
                                        end
                                    end
                                    OP_CANCEL:
                                    begin
                                        if (present_reg[cmd_idx])
                                        begin
                                            present_reg[cmd_idx] <= 1'b0;
                                            running_reg[cmd_idx] <= 1'b0;
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (stuck)
                    begin
                        running_reg[cur] <= 1'b0;
                    end
                    if (idle_now && better)
                    begin
                        best_valid_reg <= 1'b1;
                    end
                    if (idx_reg == CNT_W'(SLOTS - 1))
                    begin
                        state_reg <= ST_PICK;
                    end
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                ST_PICK:
                begin
                    if (best_valid_reg)
                    begin
                        running_reg[best_idx_reg] <= 1'b1;
                    end
                    // An empty pick reports slot zero.
                    res_reg       <= {best_valid_reg ? SLOT_W'(best_idx_reg) : SLOT_W'(0),
                                      best_valid_reg, 1'b0};
                    res_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

>>> hdl/priority_job_scheduler_core.sv
// Priority job scheduler: a table of job slots served by a single dispatch scanner.
// A submit, acknowledge, cancel or reschedule passes through the command queue and
// is answered from the result register; a dispatch scans the table one slot a cycle
// to release stuck jobs and pick the winner. A two-entry command queue lets the
// input side keep taking transfers while a scan runs, until the queue is full.
// Top level; depends on pjs_pkg, pjs_cmd_fifo and pjs_exec.
module priority_job_scheduler_core
    import pjs_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], job_slot[6:3], job_priority[22:7], time_value[54:23],
    // repeat_period[86:55], zero fill to 88 bits
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // picked_slot[3:0], picked_valid[4], op_ok[5], zero fill to 8 bits
    output logic [7:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] timeout_reg;
    cmd_t        in_cmd;
    cmd_t        q_cmd;
    logic        q_valid;
    logic        q_ready;
    res_t        res;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, timeout_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            timeout_reg <= pwdata[15:0];
        end
    end

    assign in_cmd.op     = s_tdata[2:0];
    assign in_cmd.slot   = s_tdata[6:3];
    assign in_cmd.prio   = s_tdata[22:7];
    assign in_cmd.tval   = s_tdata[54:23];
    assign in_cmd.period = s_tdata[86:55];

    pjs_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    pjs_exec #(.SLOTS(SLOTS)) u_exec (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (q_valid),
        .cmd_ready     (q_ready),
        .cmd           (q_cmd),
        .stuck_timeout (timeout_reg),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res           (res)
    );

    assign m_tdata = {2'b00, res.op_ok, res.picked_valid, res.picked_slot};

`ifndef SYNTHESIS
    a_pick_only_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[4] && m_tdata[5]))
        else $error("dispatch result carries op_ok");
    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_ready && s_tvalid && s_tready) |=> q_valid)
        else $error("command queue lost an entry");
`endif
endmodule

>>> dv/pjs_sched_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the priority job scheduler: watches the command, result and
// register channels, keeps its own copy of the job table and checks each result.
// Depends on pjs_pkg.
module pjs_sched_checker
    import pjs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          pending,
    output int          picks_seen
);

    localparam int NSLOT = 16;
    localparam logic [1:0] ADDR_TIMEOUT = 2'd0;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              valid;
        logic              ok;
    } outcome_t;

    logic                     job_present   [NSLOT];
    logic                     job_running   [NSLOT];
    logic                     job_recurring [NSLOT];
    logic signed [PRIO_W-1:0] job_prio      [NSLOT];
    logic [TIME_W-1:0]        job_due       [NSLOT];
    logic [TIME_W-1:0]        job_period    [NSLOT];
    logic [15:0]              stuck_limit;
    outcome_t                 outcome_q[$];

    // Applies one command to the shadow table and returns the result it causes.
    function automatic outcome_t apply_command(input logic [87:0] d);
        logic [OP_W-1:0]          opc;
        logic [SLOT_W-1:0]        s;
        logic signed [PRIO_W-1:0] pr;
        logic [TIME_W-1:0]        tv;
        logic [TIME_W-1:0]        per;
        outcome_t                 r;
        int                       best;
        opc  = d[2:0];
        s    = d[6:3];
        pr   = d[22:7];
        tv   = d[54:23];
        per  = d[86:55];
        r    = '0;
        best = -1;
        case (opc)
            OP_SUBMIT, OP_SUBMIT_REC:
            begin
                job_present[s]   = 1'b1;
                job_running[s]   = 1'b0;
                job_recurring[s] = (opc == OP_SUBMIT_REC);
                job_prio[s]      = pr;
                job_due[s]       = tv;
                job_period[s]    = (opc == OP_SUBMIT_REC) ? per : '0;
            end
            OP_DISPATCH:
            begin
                // Stuck release compares in 33 bits so the sum never wraps.
                for (int i = 0; i < NSLOT; i++)
                    if (job_present[i] && job_running[i] &&
                        ({1'b0, job_due[i]} + {17'd0, stuck_limit}) < {1'b0, tv})
                        job_running[i] = 1'b0;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (!job_present[i] || job_running[i] || job_due[i] > tv)
                        continue;
                    if (best < 0 || job_prio[i] > job_prio[best] ||
                        (job_prio[i] == job_prio[best] && job_due[i] < job_due[best]))
                        best = i;
                end
                if (best >= 0)
                begin
                    job_running[best] = 1'b1;
                    job_due[best]     = tv;
                    r.slot            = best[SLOT_W-1:0];
                    r.valid           = 1'b1;
                end
            end
            OP_ACK:
                if (job_present[s] && job_running[s])
                begin
                    job_running[s] = 1'b0;
                    if (job_recurring[s])
                        job_due[s] = job_due[s] + job_period[s];
                    else
                        job_present[s] = 1'b0;
                end
            OP_CANCEL:
                if (job_present[s])
                begin
                    job_present[s] = 1'b0;
                    job_running[s] = 1'b0;
                    r.ok           = 1'b1;
                end
            OP_RESCHED:
                if (job_present[s])
                begin
                    job_due[s] = tv;
                    r.ok       = 1'b1;
                end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                job_present[i]   = 1'b0;
                job_running[i]   = 1'b0;
                job_recurring[i] = 1'b0;
            end
            stuck_limit = TIMEOUT_RESET;
            outcome_q.delete();
            errors     = 0;
            pending    = 0;
            picks_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[3:0], m_tdata[4], m_tdata[5]};
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transfer, actual %h", $time, m_tdata);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: expected slot %0d valid %0b ok %0b, %s",
                                 $time, want.slot, want.valid, want.ok,
                                 $sformatf("actual slot %0d valid %0b ok %0b",
                                           got.slot, got.valid, got.ok));
                    end
                    if (got.valid)
                        picks_seen++;
                end
            end
            if (s_tvalid && s_tready)
                outcome_q = {outcome_q, apply_command(s_tdata)};
            if (psel && penable && pwrite && pready && paddr == ADDR_TIMEOUT)
                stuck_limit = pwdata[15:0];
            pending = outcome_q.size();
        end
    end

endmodule

>>> dv/priority_job_scheduler_core_test.sv
`timescale 1ns / 1ps
// Testbench top for the priority job scheduler: drives commands, register writes
// and result back-pressure, and reports the verdict. Depends on pjs_pkg,
// pjs_sched_checker and the scheduler RTL.
module priority_job_scheduler_core_test;
    import pjs_pkg::*;

    localparam int  CYCLE_LIMIT = 300000;
    localparam int  HOLD_CYCLES = 400;
    localparam int  DRAIN_WAIT  = 40;
    localparam logic [1:0] ADDR_TIMEOUT = 2'd0;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // operation[2:0], job_slot[6:3], job_priority[22:7], time_value[54:23],
    // repeat_period[86:55], zero fill to 88 bits
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // picked_slot[3:0], picked_valid[4], op_ok[5], zero fill to 8 bits
    logic [7:0]  m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    int          picks_seen;
    int          cycles;
    int          results_taken;
    int          items_sent;
    logic        no_gaps;
    logic [31:0] now_tick;

    priority_job_scheduler_core dut (.*);

    pjs_sched_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [87:0] pack_cmd(input logic [2:0] opc, input logic [3:0] s,
                                             input logic [15:0] pr, input logic [31:0] tv,
                                             input logic [31:0] per);
        return {1'b0, per, tv, pr, s, opc};
    endfunction

    task automatic send_cmd(input logic [87:0] d);
        int   gap;
        logic took;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TIMEOUT;
        pwdata  <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Half the priorities are drawn from a narrow band around zero so that ties are common.
    function automatic logic [15:0] pick_prio();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return 16'h8000;
            2:       return 16'h7fff;
            default: return 16'($urandom_range(0, 4) - 2);
        endcase
    endfunction

    task automatic random_cmd();
        int          sel;
        logic [2:0]  opc;
        logic [31:0] tv;
        logic [31:0] per;
        sel = $urandom_range(0, 99);
        tv  = now_tick + $urandom_range(0, 40) - 10;
        per = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60);
        if (sel < 16)
            opc = OP_SUBMIT;
        else if (sel < 28)
            opc = OP_SUBMIT_REC;
        else if (sel < 58)
        begin
            opc      = OP_DISPATCH;
            now_tick = now_tick + $urandom_range(0, 25);
            tv       = now_tick;
        end
        else if (sel < 76)
            opc = OP_ACK;
        else if (sel < 84)
            opc = OP_CANCEL;
        else if (sel < 93)
            opc = OP_RESCHED;
        else
        begin
            // Noise: every field drawn over its full width, including unused opcodes.
            send_cmd(pack_cmd(3'($urandom), 4'($urandom), 16'($urandom), $urandom,
                              $urandom));
            return;
        end
        send_cmd(pack_cmd(opc, 4'($urandom_range(0, 15)), pick_prio(), tv, per));
    endtask

    // Receiver: random stalls, plus one long hold-off to fill the block.
    initial
    begin
        int   gap;
        logic took;
        logic held;
        m_tready      = 1'b0;
        results_taken = 0;
        held          = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && results_taken == 150)
            begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            else
                gap = no_gaps ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = m_tvalid;
                @(posedge clk);
            end
            while (!took);
            results_taken++;
        end
    end

    initial
    begin
        logic [15:0] timeouts [4];
        cycles     = 0;
        items_sent = 0;
        no_gaps    = 1'b0;
        now_tick   = 32'd0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset timeout.
        send_cmd(pack_cmd(OP_SUBMIT,     4'd0,  16'h7fff, 32'd0,  32'd0));
        send_cmd(pack_cmd(OP_SUBMIT,     4'd15, 16'h8000, 32'd0,  32'd0));
        send_cmd(pack_cmd(OP_SUBMIT_REC, 4'd3,  16'd5,    32'd10, 32'hffffffff));
        send_cmd(pack_cmd(OP_DISPATCH,   4'd0,  16'd0,    32'd0,  32'd0));
        send_cmd(pack_cmd(OP_DISPATCH,   4'd9,  16'd0,    32'd0,  32'd0));
        send_cmd(pack_cmd(OP_DISPATCH,   4'd0,  16'd0,    32'd5,  32'd0));
        send_cmd(pack_cmd(OP_ACK,        4'd0,  16'd0,    32'd0,  32'd0));
        send_cmd(pack_cmd(OP_ACK,        4'd3,  16'd0,    32'd0,  32'd0));
        send_cmd(pack_cmd(OP_ACK,        4'd7,  16'd0,    32'd0,  32'd0));
        send_cmd(pack_cmd(OP_CANCEL,     4'd7,  16'd0,    32'd0,  32'd0));
        send_cmd(pack_cmd(OP_RESCHED,    4'd15, 16'd0,    32'd100, 32'd0));
        send_cmd(pack_cmd(OP_DISPATCH,   4'd0,  16'd0,    32'd20, 32'd0));
        send_cmd(pack_cmd(OP_ACK,        4'd3,  16'd0,    32'd0,  32'd0));
        send_cmd(pack_cmd(OP_DISPATCH,   4'd0,  16'd0,    32'd19, 32'd0));
        send_cmd(pack_cmd(OP_DISPATCH,   4'd0,  16'd0,    32'd200, 32'd0));
        send_cmd(pack_cmd(OP_SUBMIT,     4'd8,  16'd1,    32'd50, 32'd0));
        send_cmd(pack_cmd(OP_SUBMIT,     4'd9,  16'd1,    32'd50, 32'd0));
        send_cmd(pack_cmd(OP_SUBMIT,     4'd9,  16'd1,    32'd40, 32'd0));
        send_cmd(pack_cmd(OP_DISPATCH,   4'd0,  16'd0,    32'hffffffff, 32'd0));
        send_cmd(pack_cmd(OP_DISPATCH,   4'd0,  16'd0,    32'hffffffff, 32'd0));
        send_cmd(pack_cmd(OP_CANCEL,     4'd15, 16'd0,    32'd0,  32'd0));
        send_cmd(pack_cmd(OP_RESCHED,    4'd7,  16'd0,    32'd0,  32'd0));
        send_cmd(pack_cmd(3'd6,          4'd1,  16'hffff, 32'hffffffff, 32'hffffffff));
        send_cmd(pack_cmd(3'd7,          4'd2,  16'h1234, 32'd5,  32'd9));
        drain_results();

        // Random phases, each under its own timeout; one runs near the top of time.
        timeouts[0] = 16'd0;
        timeouts[1] = 16'hffff;
        timeouts[2] = 16'($urandom_range(1, 50));
        timeouts[3] = 16'd30;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_timeout(timeouts[ph]);
            no_gaps  = (ph == 2);
            now_tick = (ph == 1) ? 32'hffffff00 : $urandom_range(0, 1000);
            repeat (195) random_cmd();
            drain_results();
        end

        $display("Sent %0d commands over four timeout settings; %0d results taken, %s",
                 items_sent, results_taken, $sformatf("%0d dispatch picks.", picks_seen));
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/pjs_pkg.sv
hdl/pjs_cmd_fifo.sv
hdl/pjs_exec.sv
hdl/priority_job_scheduler_core.sv
dv/pjs_sched_checker.sv
dv/priority_job_scheduler_core_test.sv
